>>> hw/rtl/idwqc_pkg.sv
// ----------------------------------------------------------------------------
// idwqc_pkg
// Types, constants and tables shared by the spatial quality check block.
// ----------------------------------------------------------------------------
package idwqc_pkg;

    localparam int MAX_STATIONS = 1024;
    localparam int CNT_W        = $clog2(MAX_STATIONS + 1);

    localparam int MUL_A_W = 64;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W = 72;
    localparam int DIV_D_W = 64;

    localparam logic [2:0] REG_POWER_METHOD  = 3'd0;
    localparam logic [2:0] REG_MIN_WEIGHT    = 3'd1;
    localparam logic [2:0] REG_MAX_ELEV_DIFF = 3'd2;
    localparam logic [2:0] REG_ALPHA_SQ_BAD  = 3'd3;
    localparam logic [2:0] REG_ALPHA_SQ_DUB  = 3'd4;
    localparam logic [2:0] REG_WRAP_DIR      = 3'd5;

    localparam logic [1:0] RES_KEEP    = 2'd0;
    localparam logic [1:0] RES_GOOD    = 2'd1;
    localparam logic [1:0] RES_DUBIOUS = 2'd2;
    localparam logic [1:0] RES_BAD     = 2'd3;

    localparam logic KIND_HEADER = 1'b0;

    localparam logic signed [20:0] ELEV_MISSING = -21'sd99000;
    localparam logic signed [20:0] OBS_MISSING  = -21'sd99900;

    localparam logic [47:0] FRAC_ONE    = 48'h00_0001_000000;
    localparam logic [63:0] SUM_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SUM_MIN     = 64'h8000_0000_0000_0000;
    localparam logic [71:0] MEAN_CLAMP  = 72'h40000000;
    localparam logic signed [32:0] WRAP_HALF = 33'sd4608000;
    localparam logic signed [32:0] WRAP_FULL = 33'sd9216000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_W_MUL1,
        ST_W_MUL2,
        ST_W_DIV,
        ST_W_CHK,
        ST_P_MUL,
        ST_ACC,
        ST_N_END,
        ST_E_CHK,
        ST_E_DIV,
        ST_E_DIFF,
        ST_E_SQ,
        ST_E_TB,
        ST_E_TD,
        ST_EMIT
    } state_t;

    // 100^p scaled by 2^24
    function automatic logic [DIV_N_W-1:0] idw_numerator(input logic [1:0] p);
        logic [DIV_N_W-1:0] n;
        case (p)
            2'd1:    n = 72'd1677721600;
            2'd2:    n = 72'd167772160000;
            2'd3:    n = 72'd16777216000000;
            default: n = 72'd16777216;
        endcase
        return n;
    endfunction

endpackage

>>> hw/rtl/idwqc_mul.sv
// ----------------------------------------------------------------------------
// idwqc_mul
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module idwqc_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [idwqc_pkg::MUL_A_W-1:0] a,
    input  logic [idwqc_pkg::MUL_B_W-1:0] b,
    output logic                          done,
    output logic [idwqc_pkg::MUL_P_W-1:0] prod
);

    localparam int CW = $clog2(idwqc_pkg::MUL_B_W);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [idwqc_pkg::MUL_A_W-1:0] a_reg, a_next;
    logic [idwqc_pkg::MUL_B_W-1:0] b_reg, b_next;
    logic [idwqc_pkg::MUL_P_W-1:0] acc_reg, acc_next;
    logic [idwqc_pkg::MUL_A_W:0]   sum;

    always_comb begin
        sum = {1'b0, acc_reg[idwqc_pkg::MUL_P_W-1:idwqc_pkg::MUL_B_W]}
            + (b_reg[0] ? {1'b0, a_reg} : '0);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start && !busy_reg && !done_reg) begin
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = {sum, acc_reg[idwqc_pkg::MUL_B_W-1:1]};
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(idwqc_pkg::MUL_B_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

>>> hw/rtl/idwqc_div.sv
// ----------------------------------------------------------------------------
// idwqc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module idwqc_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [idwqc_pkg::DIV_N_W-1:0] dividend,
    input  logic [idwqc_pkg::DIV_D_W-1:0] divisor,
    output logic                          done,
    output logic [idwqc_pkg::DIV_N_W-1:0] quotient
);

    localparam int CW = $clog2(idwqc_pkg::DIV_N_W);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [idwqc_pkg::DIV_N_W-1:0] dvd_reg, dvd_next;
    logic [idwqc_pkg::DIV_D_W-1:0] dsr_reg, dsr_next;
    logic [idwqc_pkg::DIV_D_W-1:0] rem_reg, rem_next;
    logic [idwqc_pkg::DIV_D_W:0]   trial;
    logic [idwqc_pkg::DIV_D_W:0]   diff;
    logic                          ge;

    always_comb begin
        trial = {rem_reg, dvd_reg[idwqc_pkg::DIV_N_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        ge    = trial >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start && !busy_reg && !done_reg) begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[idwqc_pkg::DIV_D_W-1:0] : trial[idwqc_pkg::DIV_D_W-1:0];
            dvd_next = {dvd_reg[idwqc_pkg::DIV_N_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(idwqc_pkg::DIV_N_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

>>> hw/rtl/idw_neighbor_qc_flag_top.sv
// ----------------------------------------------------------------------------
// idw_neighbor_qc_flag_top
// Spatial quality check of one observation against the inverse distance
// weighted mean of its neighbors.
// ----------------------------------------------------------------------------
// One item is worked on at a time; s_tready is high only while the block is
// idle. A neighbor runs the bit-serial multiplier to form distance^p (one
// pass for p=2, two for p=3), then a pass of the bit-serial divider forms the
// weight, and one more multiplier pass forms weight*observation; p=0 or a zero
// distance skips the weight, a rejected neighbor skips the product. The last
// item adds the mean (one divider pass), the squared difference and the two
// thresholds (three multiplier passes) unless the flag is kept, and in either
// case any wait for the output register. A finished result waits in the
// output register while the next item is taken in.
// ----------------------------------------------------------------------------
module idw_neighbor_qc_flag_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // distance, elevation, observation, is_self, target_obs, target_elev,
    // variance, incoming_protected, zero fill
    input  logic [151:0] s_tdata,
    input  logic         s_tlast,
    // kind
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_code, zero fill
    output logic [7:0]   m_tdata,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [47:0]  cfg_wdata
);

    idwqc_pkg::state_t state_reg, state_next;

    logic [1:0]  power_reg;
    logic [47:0] min_w_reg;
    logic [19:0] max_ed_reg;
    logic [15:0] a_bad_reg;
    logic [15:0] a_dub_reg;
    logic        wrap_reg;

    logic [20:0]        d_reg, d_next;
    logic signed [20:0] elev_reg, elev_next;
    logic signed [20:0] obs_reg, obs_next;
    logic               self_reg, self_next;
    logic               last_reg, last_next;
    logic [47:0]        w_reg, w_next;

    logic signed [20:0] hobs_reg, hobs_next;
    logic signed [20:0] helev_reg, helev_next;
    logic [39:0]        hvar_reg, hvar_next;
    logic               hprot_reg, hprot_next;

    logic signed [63:0]            wsum_reg, wsum_next;
    logic [63:0]                   wtsum_reg, wtsum_next;
    logic [idwqc_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic signed [31:0]            mean_reg, mean_next;
    logic [31:0]                   dmag_reg, dmag_next;
    logic [63:0]                   dsq_reg, dsq_next;
    logic [63:0]                   tb_reg, tb_next;
    logic [1:0]                    code_reg, code_next;
    logic                          mval_reg, mval_next;
    logic [1:0]                    mcode_reg, mcode_next;

    logic                          mul_start, mul_done;
    logic [idwqc_pkg::MUL_A_W-1:0] mul_a;
    logic [idwqc_pkg::MUL_B_W-1:0] mul_b;
    logic [idwqc_pkg::MUL_P_W-1:0] mul_prod;
    logic                          div_start, div_done;
    logic [idwqc_pkg::DIV_N_W-1:0] div_n;
    logic [idwqc_pkg::DIV_D_W-1:0] div_d;
    logic [idwqc_pkg::DIV_N_W-1:0] div_q;

    logic               accept, out_free;
    logic signed [21:0] gap;
    logic [21:0]        gap_mag;
    logic               pass, keep;
    logic [20:0]        obs_mag;
    logic [63:0]        wsum_mag;
    logic               psat;
    logic [63:0]        pmag;
    logic signed [63:0] pval;
    logic signed [64:0] sum65;
    logic [64:0]        wt65;
    logic [30:0]        qc;
    logic signed [32:0] diff;
    logic [63:0]        td;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !mval_reg || m_tready;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_reg  <= 2'd2;
            min_w_reg  <= '0;
            max_ed_reg <= 20'd50000;
            a_bad_reg  <= 16'd1024;
            a_dub_reg  <= 16'd256;
            wrap_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                idwqc_pkg::REG_POWER_METHOD:  power_reg  <= cfg_wdata[1:0];
                idwqc_pkg::REG_MIN_WEIGHT:    min_w_reg  <= cfg_wdata;
                idwqc_pkg::REG_MAX_ELEV_DIFF: max_ed_reg <= cfg_wdata[19:0];
                idwqc_pkg::REG_ALPHA_SQ_BAD:  a_bad_reg  <= cfg_wdata[15:0];
                idwqc_pkg::REG_ALPHA_SQ_DUB:  a_dub_reg  <= cfg_wdata[15:0];
                idwqc_pkg::REG_WRAP_DIR:      wrap_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // neighbor tests and evaluation guards
    always_comb begin
        gap     = 22'(helev_reg) - 22'(elev_reg);
        gap_mag = gap[21] ? 22'(-gap) : 22'(gap);
        pass = (w_reg >= min_w_reg) && (obs_reg > idwqc_pkg::OBS_MISSING)
            && (elev_reg > idwqc_pkg::ELEV_MISSING) && !self_reg
            && (gap_mag <= {2'b00, max_ed_reg})
            && (cnt_reg < idwqc_pkg::CNT_W'(idwqc_pkg::MAX_STATIONS));
        keep = hprot_reg || (helev_reg <= idwqc_pkg::ELEV_MISSING)
            || (cnt_reg == '0) || (wtsum_reg == '0);
        obs_mag  = obs_reg[20] ? 21'(-obs_reg) : 21'(obs_reg);
        wsum_mag = wsum_reg[63] ? 64'(-wsum_reg) : 64'(wsum_reg);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            idwqc_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == idwqc_pkg::KIND_HEADER) begin
                        state_next = s_tlast ? idwqc_pkg::ST_EMIT : idwqc_pkg::ST_IDLE;
                    end else if (power_reg == 2'd0 || s_tdata[20:0] == '0) begin
                        state_next = idwqc_pkg::ST_W_CHK;
                    end else if (power_reg == 2'd1) begin
                        state_next = idwqc_pkg::ST_W_DIV;
                    end else begin
                        state_next = idwqc_pkg::ST_W_MUL1;
                    end
                end
            end
            idwqc_pkg::ST_W_MUL1: begin
                if (mul_done) begin
                    state_next = (power_reg == 2'd2) ? idwqc_pkg::ST_W_DIV
                                                     : idwqc_pkg::ST_W_MUL2;
                end
            end
            idwqc_pkg::ST_W_MUL2: if (mul_done) state_next = idwqc_pkg::ST_W_DIV;
            idwqc_pkg::ST_W_DIV:  if (div_done) state_next = idwqc_pkg::ST_W_CHK;
            idwqc_pkg::ST_W_CHK: begin
                state_next = pass ? idwqc_pkg::ST_P_MUL : idwqc_pkg::ST_N_END;
            end
            idwqc_pkg::ST_P_MUL:  if (mul_done) state_next = idwqc_pkg::ST_ACC;
            idwqc_pkg::ST_ACC:    state_next = idwqc_pkg::ST_N_END;
            idwqc_pkg::ST_N_END: begin
                state_next = last_reg ? idwqc_pkg::ST_E_CHK : idwqc_pkg::ST_IDLE;
            end
            idwqc_pkg::ST_E_CHK: begin
                state_next = keep ? idwqc_pkg::ST_EMIT : idwqc_pkg::ST_E_DIV;
            end
            idwqc_pkg::ST_E_DIV:  if (div_done) state_next = idwqc_pkg::ST_E_DIFF;
            idwqc_pkg::ST_E_DIFF: state_next = idwqc_pkg::ST_E_SQ;
            idwqc_pkg::ST_E_SQ:   if (mul_done) state_next = idwqc_pkg::ST_E_TB;
            idwqc_pkg::ST_E_TB:   if (mul_done) state_next = idwqc_pkg::ST_E_TD;
            idwqc_pkg::ST_E_TD:   if (mul_done) state_next = idwqc_pkg::ST_EMIT;
            idwqc_pkg::ST_EMIT:   if (out_free) state_next = idwqc_pkg::ST_IDLE;
            default:              state_next = idwqc_pkg::ST_IDLE;
        endcase
    end

    // outputs and unit operands
    always_comb begin
        s_tready  = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_n     = '0;
        div_d     = '0;
        case (state_reg)
            idwqc_pkg::ST_IDLE: s_tready = 1'b1;
            idwqc_pkg::ST_W_MUL1: begin
                mul_start = 1'b1;
                mul_a     = 64'(d_reg);
                mul_b     = 32'(d_reg);
            end
            idwqc_pkg::ST_W_MUL2: begin
                mul_start = 1'b1;
                mul_a     = mul_prod[63:0];
                mul_b     = 32'(d_reg);
            end
            idwqc_pkg::ST_W_DIV: begin
                div_start = 1'b1;
                div_n     = idwqc_pkg::idw_numerator(power_reg);
                div_d     = (power_reg == 2'd1) ? 64'(d_reg) : mul_prod[63:0];
            end
            idwqc_pkg::ST_P_MUL: begin
                mul_start = 1'b1;
                mul_a     = 64'(w_reg);
                mul_b     = 32'(obs_mag);
            end
            idwqc_pkg::ST_E_DIV: begin
                div_start = 1'b1;
                div_n     = {wsum_mag, 8'h00};
                div_d     = wtsum_reg;
            end
            idwqc_pkg::ST_E_SQ: begin
                mul_start = 1'b1;
                mul_a     = 64'(dmag_reg);
                mul_b     = dmag_reg;
            end
            idwqc_pkg::ST_E_TB: begin
                mul_start = 1'b1;
                mul_a     = 64'(hvar_reg);
                mul_b     = 32'(a_bad_reg);
            end
            idwqc_pkg::ST_E_TD: begin
                mul_start = 1'b1;
                mul_a     = 64'(hvar_reg);
                mul_b     = 32'(a_dub_reg);
            end
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        d_next     = d_reg;
        elev_next  = elev_reg;
        obs_next   = obs_reg;
        self_next  = self_reg;
        last_next  = last_reg;
        w_next     = w_reg;
        hobs_next  = hobs_reg;
        helev_next = helev_reg;
        hvar_next  = hvar_reg;
        hprot_next = hprot_reg;
        wsum_next  = wsum_reg;
        wtsum_next = wtsum_reg;
        cnt_next   = cnt_reg;
        mean_next  = mean_reg;
        dmag_next  = dmag_reg;
        dsq_next   = dsq_reg;
        tb_next    = tb_reg;
        code_next  = code_reg;
        mval_next  = mval_reg && !m_tready;
        mcode_next = mcode_reg;

        psat  = |mul_prod[idwqc_pkg::MUL_P_W-1:63];
        pmag  = psat ? idwqc_pkg::SUM_MAX : {1'b0, mul_prod[62:0]};
        pval  = obs_reg[20] ? (psat ? idwqc_pkg::SUM_MIN : 64'(-pmag)) : pmag;
        sum65 = {wsum_reg[63], wsum_reg} + {pval[63], pval};
        wt65  = {1'b0, wtsum_reg} + 65'(w_reg);
        qc    = (div_q >= idwqc_pkg::MEAN_CLAMP) ? 31'h40000000 : div_q[30:0];
        diff  = 33'(mean_reg) - 33'($signed({hobs_reg, 8'h00}));
        if (wrap_reg && diff > idwqc_pkg::WRAP_HALF) begin
            diff = diff - idwqc_pkg::WRAP_FULL;
        end else if (wrap_reg && diff < -idwqc_pkg::WRAP_HALF) begin
            diff = diff + idwqc_pkg::WRAP_FULL;
        end
        td = {mul_prod[55:0], 8'h00};

        case (state_reg)
            idwqc_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == idwqc_pkg::KIND_HEADER) begin
                        hobs_next  = s_tdata[84:64];
                        helev_next = s_tdata[105:85];
                        hvar_next  = s_tdata[145:106];
                        hprot_next = s_tdata[146];
                        wsum_next  = '0;
                        wtsum_next = '0;
                        cnt_next   = '0;
                        code_next  = idwqc_pkg::RES_KEEP;
                    end else begin
                        d_next    = s_tdata[20:0];
                        elev_next = s_tdata[41:21];
                        obs_next  = s_tdata[62:42];
                        self_next = s_tdata[63];
                        last_next = s_tlast;
                        w_next    = (power_reg == 2'd0) ? idwqc_pkg::FRAC_ONE : '0;
                    end
                end
            end
            idwqc_pkg::ST_W_DIV: if (div_done) w_next = div_q[47:0];
            idwqc_pkg::ST_ACC: begin
                if (sum65[64] != sum65[63]) begin
                    wsum_next = sum65[64] ? idwqc_pkg::SUM_MIN : idwqc_pkg::SUM_MAX;
                end else begin
                    wsum_next = sum65[63:0];
                end
                wtsum_next = (wt65 > 65'(idwqc_pkg::SUM_MAX)) ? idwqc_pkg::SUM_MAX
                                                               : wt65[63:0];
                cnt_next = cnt_reg + 1'b1;
            end
            idwqc_pkg::ST_E_CHK: code_next = idwqc_pkg::RES_KEEP;
            idwqc_pkg::ST_E_DIV: begin
                if (div_done) begin
                    mean_next = wsum_reg[63] ? -32'(qc) : 32'(qc);
                end
            end
            idwqc_pkg::ST_E_DIFF: begin
                dmag_next = diff[32] ? 32'(-diff) : 32'(diff);
            end
            idwqc_pkg::ST_E_SQ: if (mul_done) dsq_next = mul_prod[63:0];
            idwqc_pkg::ST_E_TB: if (mul_done) tb_next = td;
            idwqc_pkg::ST_E_TD: begin
                if (mul_done) begin
                    if (dsq_reg >= tb_reg) begin
                        code_next = idwqc_pkg::RES_BAD;
                    end else if (dsq_reg >= td) begin
                        code_next = idwqc_pkg::RES_DUBIOUS;
                    end else begin
                        code_next = idwqc_pkg::RES_GOOD;
                    end
                end
            end
            idwqc_pkg::ST_EMIT: begin
                if (out_free) begin
                    mval_next  = 1'b1;
                    mcode_next = code_reg;
                    wsum_next  = '0;
                    wtsum_next = '0;
                    cnt_next   = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= idwqc_pkg::ST_IDLE;
            mval_reg  <= 1'b0;
            wsum_reg  <= '0;
            wtsum_reg <= '0;
            cnt_reg   <= '0;
            hobs_reg  <= '0;
            helev_reg <= '0;
            hvar_reg  <= '0;
            hprot_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mval_reg  <= mval_next;
            wsum_reg  <= wsum_next;
            wtsum_reg <= wtsum_next;
            cnt_reg   <= cnt_next;
            hobs_reg  <= hobs_next;
            helev_reg <= helev_next;
            hvar_reg  <= hvar_next;
            hprot_reg <= hprot_next;
        end
        d_reg     <= d_next;
        elev_reg  <= elev_next;
        obs_reg   <= obs_next;
        self_reg  <= self_next;
        last_reg  <= last_next;
        w_reg     <= w_next;
        mean_reg  <= mean_next;
        dmag_reg  <= dmag_next;
        dsq_reg   <= dsq_next;
        tb_reg    <= tb_next;
        code_reg  <= code_next;
        mcode_reg <= mcode_next;
    end

    idwqc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    idwqc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_tvalid = mval_reg;
    assign m_tdata  = {6'b000000, mcode_reg};

endmodule

>>> verif/idwqc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// idwqc_checker
// Watches the configuration port and both stream channels of the spatial
// quality check block, predicts the flag of every check and compares it.
// ----------------------------------------------------------------------------
module idwqc_checker
    import idwqc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [151:0] s_tdata,
    input  logic         s_tlast,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [7:0]   m_tdata,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [47:0]  cfg_wdata,
    output int           n_fail,
    output int           n_pending
);

    logic [1:0]  cfg_power;
    logic [47:0] cfg_min_w;
    logic [19:0] cfg_max_gap;
    logic [15:0] cfg_a_bad;
    logic [15:0] cfg_a_dub;
    logic        cfg_wrap;

    logic signed [63:0] obs_wsum;
    logic [63:0]        wgt_total;
    int                 n_used;
    logic signed [20:0] hold_obs;
    logic signed [20:0] hold_elev;
    logic [39:0]        hold_var;
    logic               hold_prot;

    logic [1:0] flag_q[$];

    function automatic logic [47:0] idw_weight(logic [1:0] p, logic [20:0] d);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] w;
        num = 64'd16777216;
        den = 64'd1;
        if (p == 2'd0) return FRAC_ONE;
        if (d == 21'd0) return 48'd0;
        for (int k = 0; k < int'(p); k++) begin
            num = num * 64'd100;
            den = den * {43'd0, d};
        end
        w = num / den;
        return (w > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : w[47:0];
    endfunction

    task automatic accumulate(logic signed [20:0] obs, logic [47:0] w);
        logic [127:0]       pm;
        logic signed [65:0] prod;
        logic signed [65:0] acc;
        logic [64:0]        tot;
        logic [63:0]        mag;
        mag = (obs < 0) ? 64'(-longint'(obs)) : 64'(longint'(obs));
        pm = 128'(mag) * 128'(w);
        if (pm > 128'(SUM_MAX))
            prod = (obs < 0) ? -66'sd9223372036854775808 : 66'sd9223372036854775807;
        else if (obs < 0)
            prod = -$signed({2'b00, pm[63:0]});
        else
            prod = $signed({2'b00, pm[63:0]});
        acc = 66'(obs_wsum) + prod;
        if (acc > 66'sd9223372036854775807) obs_wsum = SUM_MAX;
        else if (acc < -66'sd9223372036854775808) obs_wsum = SUM_MIN;
        else obs_wsum = acc[63:0];
        tot = {1'b0, wgt_total} + {17'd0, w};
        wgt_total = (tot > {1'b0, SUM_MAX}) ? SUM_MAX : tot[63:0];
        n_used++;
    endtask

    function automatic logic [1:0] flag_of_check();
        logic [63:0]     mag;
        logic [63:0]     quo;
        logic [64:0]     rem;
        longint          mean;
        longint          diff;
        longint unsigned dm;
        longint unsigned dsq;
        longint unsigned tb;
        longint unsigned td;
        if (hold_prot || hold_elev <= ELEV_MISSING || n_used == 0 || wgt_total == 0)
            return RES_KEEP;
        mag = (obs_wsum < 0) ? 64'(-obs_wsum) : obs_wsum;
        quo = mag / wgt_total;
        rem = {1'b0, mag % wgt_total};
        if (quo >= 64'd4194304) begin
            quo = 64'd4194304;
            rem = '0;
        end
        for (int k = 0; k < 8; k++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= {1'b0, wgt_total}) begin
                rem = rem - {1'b0, wgt_total};
                quo[0] = 1'b1;
            end
        end
        mean = (obs_wsum < 0) ? -longint'(quo) : longint'(quo);
        diff = mean - longint'(hold_obs) * 256;
        if (cfg_wrap) begin
            if (diff > 64'sd4608000) diff = diff - 64'sd9216000;
            else if (diff < -64'sd4608000) diff = diff + 64'sd9216000;
        end
        dm = (diff < 0) ? longint'(-diff) : longint'(diff);
        dsq = dm * dm;
        tb = (longint'(cfg_a_bad) * longint'(hold_var)) << 8;
        td = (longint'(cfg_a_dub) * longint'(hold_var)) << 8;
        if (dsq >= tb) return RES_BAD;
        if (dsq >= td) return RES_DUBIOUS;
        return RES_GOOD;
    endfunction

    always @(posedge aclk) begin
        logic [1:0]         exp_flag;
        logic [20:0]        nbr_dist;
        logic signed [20:0] elev;
        logic signed [20:0] obs;
        logic [47:0]        w;
        longint             gap;
        if (!aresetn) begin
            cfg_power   = 2'd2;
            cfg_min_w   = '0;
            cfg_max_gap = 20'd50000;
            cfg_a_bad   = 16'd1024;
            cfg_a_dub   = 16'd256;
            cfg_wrap    = 1'b0;
            obs_wsum    = '0;
            wgt_total   = '0;
            n_used      = 0;
            hold_obs    = '0;
            hold_elev   = '0;
            hold_var    = '0;
            hold_prot   = 1'b0;
            flag_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_POWER_METHOD:  cfg_power   = cfg_wdata[1:0];
                    REG_MIN_WEIGHT:    cfg_min_w   = cfg_wdata;
                    REG_MAX_ELEV_DIFF: cfg_max_gap = cfg_wdata[19:0];
                    REG_ALPHA_SQ_BAD:  cfg_a_bad   = cfg_wdata[15:0];
                    REG_ALPHA_SQ_DUB:  cfg_a_dub   = cfg_wdata[15:0];
                    REG_WRAP_DIR:      cfg_wrap    = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (flag_q.size() == 0) begin
                    $error("result_code: unexpected transfer, actual %0d", m_tdata[1:0]);
                    n_fail++;
                end else begin
                    exp_flag = flag_q.pop_front();
                    if (m_tdata[1:0] !== exp_flag) begin
                        $error("result_code: expected %0d, actual %0d", exp_flag,
                               m_tdata[1:0]);
                        n_fail++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == KIND_HEADER) begin
                    hold_obs  = s_tdata[84:64];
                    hold_elev = s_tdata[105:85];
                    hold_var  = s_tdata[145:106];
                    hold_prot = s_tdata[146];
                    obs_wsum  = '0;
                    wgt_total = '0;
                    n_used    = 0;
                end else begin
                    nbr_dist = s_tdata[20:0];
                    elev     = s_tdata[41:21];
                    obs      = s_tdata[62:42];
                    w        = idw_weight(cfg_power, nbr_dist);
                    gap      = longint'(hold_elev) - longint'(elev);
                    if (gap < 0) gap = -gap;
                    if (w >= cfg_min_w && obs > OBS_MISSING && elev > ELEV_MISSING &&
                        !s_tdata[63] && gap <= longint'(cfg_max_gap) &&
                        n_used < MAX_STATIONS)
                        accumulate(obs, w);
                end
                if (s_tlast) begin
                    flag_q.push_back(flag_of_check());
                    obs_wsum  = '0;
                    wgt_total = '0;
                    n_used    = 0;
                end
            end
        end
        n_pending = flag_q.size();
    end

    initial begin
        n_fail    = 0;
        n_pending = 0;
    end

endmodule

>>> verif/idw_neighbor_qc_flag_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// idw_neighbor_qc_flag_top_tb
// Drives header and neighbor transfers into the spatial quality check block
// under several register settings and idle patterns; a checker beside the
// block predicts and compares every flag.
// ----------------------------------------------------------------------------
module idw_neighbor_qc_flag_top_tb;
    import idwqc_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] s_tdata;
    logic         s_tlast;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;
    logic         cfg_wr_en;
    logic [2:0]   cfg_index;
    logic [47:0]  cfg_wdata;
    int           n_fail;
    int           n_pending;
    int           send_pct;
    int           recv_pct;
    logic         dir_mode;

    idw_neighbor_qc_flag_top i_dut (.*);

    idwqc_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver stalls
    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_pct);

    task automatic put_item(logic kind, logic last, logic [20:0] nbr_dist, logic [20:0] elev,
                            logic [20:0] obs, logic self, logic [20:0] tobs,
                            logic [20:0] telev, logic [39:0] vari, logic prot);
        while ($urandom_range(99) < send_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, prot, vari, telev, tobs, self, obs, elev, nbr_dist};
        s_tlast  <= last;
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (n_pending != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
    endtask

    function automatic logic [20:0] odd_value();
        case ($urandom_range(5))
            0: return -21'sd100000;
            1: return 21'sd1000000;
            2: return -21'sd99000;
            3: return -21'sd99900;
            4: return -21'sd98999;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_check(int n_nbr);
        logic [20:0] tobs;
        logic [20:0] telev;
        logic [39:0] vari;
        logic [20:0] nbr_dist;
        logic [20:0] elev;
        logic [20:0] obs;
        logic        broken;
        tobs  = dir_mode ? 21'($urandom_range(36000)) :
                (($urandom_range(9) == 0) ? odd_value() : 21'($urandom_range(200000)) - 21'd50000);
        telev = ($urandom_range(9) == 0) ? odd_value() : 21'($urandom_range(300000));
        vari  = 40'({$urandom, $urandom} >> $urandom_range(63, 24));
        broken = ($urandom_range(19) == 0);
        put_item(KIND_HEADER, ($urandom_range(19) == 0), $urandom, $urandom, $urandom,
                 $urandom, tobs, telev, vari, ($urandom_range(9) == 0));
        for (int k = 0; k < n_nbr; k++) begin
            case ($urandom_range(19))
                0:       nbr_dist = 21'd0;
                1, 2:    nbr_dist = 21'($urandom_range(2000000));
                default: nbr_dist = 21'($urandom_range(50000, 1));
            endcase
            elev = ($urandom_range(6) == 0) ? odd_value() :
                   21'(telev + $urandom_range(60000) - 30000);
            if ($urandom_range(9) == 0) obs = odd_value();
            else if (dir_mode) obs = 21'($urandom_range(36000));
            else obs = 21'(tobs + $urandom_range(8000) - 4000);
            put_item(~KIND_HEADER, (k == n_nbr - 1) && !broken, nbr_dist, elev, obs,
                     ($urandom_range(19) == 0), $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        int sent;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        s_tuser   = KIND_HEADER;
        m_tready  = 1'b1;
        cfg_wr_en = 1'b0;
        cfg_index = REG_POWER_METHOD;
        cfg_wdata = '0;
        send_pct  = 0;
        recv_pct  = 0;
        dir_mode  = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // neighbor before any header, lone header, protected, missing target elevation
        put_item(~KIND_HEADER, 1, 21'd100, 21'd0, 21'd500, 0, 0, 0, 0, 0);
        put_item(KIND_HEADER, 1, 0, 0, 0, 0, 21'd1000, 21'd1000, 40'd100, 0);
        put_item(KIND_HEADER, 0, 0, 0, 0, 0, 21'd1000, 21'd1000, 40'd100, 1);
        put_item(~KIND_HEADER, 1, 21'd500, 21'd1000, 21'd900, 0, 0, 0, 0, 0);
        put_item(KIND_HEADER, 0, 0, 0, 0, 0, 21'd1000, -21'sd99000, 40'd100, 0);
        put_item(~KIND_HEADER, 1, 21'd500, 21'd1000, 21'd900, 0, 0, 0, 0, 0);
        // rejected neighbors of several kinds, then a few that count
        put_item(KIND_HEADER, 0, 0, 0, 0, 0, 21'd2000, 21'd5000, 40'd0, 0);
        put_item(~KIND_HEADER, 0, 21'd0, 21'd5000, 21'd2100, 0, 0, 0, 0, 0);
        put_item(~KIND_HEADER, 0, 21'd300, 21'd5000, 21'd2100, 1, 0, 0, 0, 0);
        put_item(~KIND_HEADER, 0, 21'd300, 21'd5000, -21'sd99900, 0, 0, 0, 0, 0);
        put_item(~KIND_HEADER, 0, 21'd300, -21'sd99000, 21'd2100, 0, 0, 0, 0, 0);
        put_item(~KIND_HEADER, 0, 21'd300, 21'd60000, 21'd2100, 0, 0, 0, 0, 0);
        put_item(~KIND_HEADER, 0, 21'd2000000, 21'd5000, 21'd1000000, 0, 0, 0, 0, 0);
        put_item(~KIND_HEADER, 0, 21'd400, 21'd6000, -21'sd99899, 0, 0, 0, 0, 0);
        put_item(~KIND_HEADER, 1, 21'd250, 21'd4000, -21'sd100000, 0, 0, 0, 0, 0);
        // extremes of the header and the smallest nonzero distance
        put_item(KIND_HEADER, 0, 0, 0, 0, 0, -21'sd100000, 21'd1000000, 40'hFF_FFFF_FFFF, 0);
        put_item(~KIND_HEADER, 1, 21'd1, 21'd1000000, 21'd1000000, 0, 0, 0, 0, 0);
        put_item(KIND_HEADER, 0, 0, 0, 0, 0, 21'd1000000, 21'd0, 40'd1, 0);
        put_item(~KIND_HEADER, 1, 21'd1, -21'sd98999, -21'sd100000, 0, 0, 0, 0, 0);

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            case (ph % 4)
                0: begin send_pct = 0;  recv_pct = 0;  end
                1: begin send_pct = 49; recv_pct = 0;  end
                2: begin send_pct = 0;  recv_pct = 49; end
                default: begin send_pct = 30; recv_pct = 30; end
            endcase
            case (ph)
                1: begin
                    write_reg(REG_POWER_METHOD, 48'd0);
                    write_reg(REG_MIN_WEIGHT, 48'd0);
                    write_reg(REG_MAX_ELEV_DIFF, 48'd0);
                    write_reg(REG_ALPHA_SQ_BAD, 48'd0);
                    write_reg(REG_ALPHA_SQ_DUB, 48'd0);
                    write_reg(REG_WRAP_DIR, 48'd0);
                    dir_mode = 1'b0;
                end
                2: begin
                    write_reg(REG_POWER_METHOD, 48'd3);
                    write_reg(REG_MIN_WEIGHT, 48'hFFFF_FFFF_FFFF);
                    write_reg(REG_MAX_ELEV_DIFF, 48'd1000000);
                    write_reg(REG_ALPHA_SQ_BAD, 48'd65535);
                    write_reg(REG_ALPHA_SQ_DUB, 48'd65535);
                    write_reg(REG_WRAP_DIR, 48'd1);
                    dir_mode = 1'b1;
                end
                default: if (ph > 0) begin
                    dir_mode = $urandom_range(1);
                    write_reg(REG_POWER_METHOD, 48'($urandom_range(3)));
                    write_reg(REG_MIN_WEIGHT, (ph == 5) ? 48'd0 :
                              48'($urandom_range(3) == 0 ? {$urandom, $urandom} :
                                  $urandom_range(1 << 20)));
                    write_reg(REG_MAX_ELEV_DIFF, (ph == 5) ? 48'd1000000 :
                              48'($urandom_range(1000000)));
                    write_reg(REG_ALPHA_SQ_BAD, 48'($urandom_range(65535)));
                    write_reg(REG_ALPHA_SQ_DUB, 48'($urandom_range(2048)));
                    write_reg(REG_WRAP_DIR, 48'(dir_mode));
                end
            endcase
            // count limit: one check with more neighbors than the block keeps
            if (ph == 5) run_check(MAX_STATIONS + 6);
            sent = 0;
            while (sent < 100) begin
                if ($urandom_range(99) < 8) begin
                    put_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, {$urandom, $urandom}, $urandom);
                    sent++;
                end else begin
                    int n;
                    n = $urandom_range(6, 1);
                    run_check(n);
                    sent += n + 1;
                end
            end
        end
        drain();
        if (n_fail == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
